### rtl/core/dmst_pkg.sv
// Shared constants and word layouts for the direct-mapped search table.
`timescale 1ns / 1ps
`default_nettype none

package dmst_pkg;

    localparam int INDEX_BITS   = 16;
    localparam int TABLE_DEPTH  = 1 << INDEX_BITS;
    localparam int KEY_W        = 64;
    localparam int TAG_W        = 32;
    localparam int DEPTH_W      = 8;
    localparam int GEN_W        = 8;
    localparam int MOVE_W       = 16;
    localparam int VALUE_W      = 16;
    localparam int BOUND_W      = 2;
    localparam int WORD_W       = 48;

    localparam logic [DEPTH_W:0]   DEPTH_MARGIN = (DEPTH_W + 1)'(4);

    localparam logic               CMD_PROBE    = 1'b0;
    localparam logic               CMD_STORE    = 1'b1;

    localparam logic [BOUND_W-1:0] BND_NONE     = 2'd0;
    localparam logic [BOUND_W-1:0] BND_UPPER    = 2'd1;
    localparam logic [BOUND_W-1:0] BND_LOWER    = 2'd2;
    localparam logic [BOUND_W-1:0] BND_EXACT    = 2'd3;

    // Tag / depth / generation word: tag [47:16], depth [15:8], gen [7:0]
    typedef struct packed {
        logic [TAG_W-1:0]   tag;
        logic [DEPTH_W-1:0] depth;
        logic [GEN_W-1:0]   gen_bound;
    } tdg_word_t;

    // Move / score / eval word: move [47:32], score [31:16], eval [15:0]
    typedef struct packed {
        logic [MOVE_W-1:0]  move;
        logic [VALUE_W-1:0] score;
        logic [VALUE_W-1:0] eval;
    } mse_word_t;

    typedef struct packed {
        logic      hit;
        logic      replaced;
        tdg_word_t tdg;
        mse_word_t mse;
    } result_t;

endpackage

`default_nettype wire

### rtl/core/dmst_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module dmst_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 65536
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Read-first: a read at the written address returns the old word.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### rtl/core/direct_mapped_search_table.sv
// Direct-mapped search table: probe/store over two entry memories.
`timescale 1ns / 1ps
`default_nettype none

// Usage
//   Input channel (in_valid / in_stall): one word per probe or store. The low
//   INDEX_BITS bits of position_key pick the entry, bits 63..32 are the tag.
//   Output channel (out_valid / out_stall): exactly one result word per input
//   word, in order, reporting the entry as it stood before that item, plus
//   hit (probes) or replaced (stores).
//   Configuration: cfg_wr_en / cfg_wr_data load search_generation, which is
//   ORed with the bound kind into the stored gen/bound byte. Write it only
//   while no item is in flight.
//   Pipeline: the accepting edge registers the memory read and the item into
//   the compute stage, which then compares, writes back and registers the
//   result in the output register once that register is free or drains.
//   Throughput: one item per cycle while out_stall is low, set by the single read and single write
//   port of each entry memory; a store to the same entry as the item just
//   behind it is forwarded, so back-to-back hits on one entry run at full rate.
//   Reset: both memories are swept to zero, one entry per cycle, over all
//   2^INDEX_BITS entries (65536 at the default size); in_stall stays high
//   during the sweep. Configuration writes are taken throughout.
//   Stalls: a stalled result holds in the output register; the compute stage
//   holds behind it, and in_stall rises only when that stage is full too.

module direct_mapped_search_table
    import dmst_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,

    input  wire logic                      cfg_wr_en,
    input  wire logic [GEN_W-1:0]          cfg_wr_data,

    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire logic                      cmd,
    input  wire logic [KEY_W-1:0]          position_key,
    input  wire logic signed [VALUE_W-1:0] score_in,
    input  wire logic signed [VALUE_W-1:0] static_eval_in,
    input  wire logic [BOUND_W-1:0]        bound_kind,
    input  wire logic [DEPTH_W-1:0]        search_depth,
    input  wire logic [MOVE_W-1:0]         best_move_in,

    output logic                           out_valid,
    input  wire logic                      out_stall,
    output logic                           hit,
    output logic                           replaced,
    output logic [TAG_W-1:0]               entry_tag,
    output logic [MOVE_W-1:0]              entry_move,
    output logic signed [VALUE_W-1:0]      entry_score,
    output logic signed [VALUE_W-1:0]      entry_eval,
    output logic [DEPTH_W-1:0]             entry_depth,
    output logic [GEN_W-1:0]               entry_gen_bound
);

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    logic                  clr_active_reg, clr_active_next;
    logic [INDEX_BITS-1:0] clr_addr_reg,   clr_addr_next;
    logic [GEN_W-1:0]      search_gen_reg, search_gen_next;
    logic                  s1_valid_reg,   s1_valid_next;
    logic                  out_valid_reg,  out_valid_next;
    logic                  fwd_valid_reg,  fwd_valid_next;

    // Payload registers of the compute stage, forward slot and result
    logic                  s1_cmd_reg;
    logic [INDEX_BITS-1:0] s1_idx_reg;
    logic [TAG_W-1:0]      s1_tag_reg;
    logic [VALUE_W-1:0]    s1_score_reg;
    logic [VALUE_W-1:0]    s1_eval_reg;
    logic [BOUND_W-1:0]    s1_bound_reg;
    logic [DEPTH_W-1:0]    s1_depth_reg;
    logic [MOVE_W-1:0]     s1_move_reg;

    logic [INDEX_BITS-1:0] fwd_idx_reg;
    tdg_word_t             fwd_tdg_reg;
    mse_word_t             fwd_mse_reg;

    result_t               res_reg, res_next;

    // ------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------
    logic in_accept;
    logic s1_go;

    // Advance the compute stage when the output register is free or drains.
    assign s1_go     = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = clr_active_reg || (s1_valid_reg && !s1_go);
    assign in_accept = in_valid && !in_stall;

    // ------------------------------------------------------------------
    // Entry memories
    // ------------------------------------------------------------------
    logic                  mem_wr_en;
    logic [INDEX_BITS-1:0] mem_wr_addr;
    tdg_word_t             tdg_wr_data, tdg_rd_data;
    mse_word_t             mse_wr_data, mse_rd_data;
    tdg_word_t             tdg_new;
    mse_word_t             mse_new;
    logic                  do_replace;

    dmst_ram #(
        .WIDTH (WORD_W),
        .DEPTH (TABLE_DEPTH)
    ) u_tdg_ram (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (tdg_wr_data),
        .rd_en   (in_accept),
        .rd_addr (position_key[INDEX_BITS-1:0]),
        .rd_data (tdg_rd_data)
    );

    dmst_ram #(
        .WIDTH (WORD_W),
        .DEPTH (TABLE_DEPTH)
    ) u_mse_ram (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mse_wr_data),
        .rd_en   (in_accept),
        .rd_addr (position_key[INDEX_BITS-1:0]),
        .rd_data (mse_rd_data)
    );

    // The sweep owns the write port until it finishes; no item runs then.
    always_comb
    begin
        if (clr_active_reg)
        begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_addr_reg;
            tdg_wr_data = '0;
            mse_wr_data = '0;
        end
        else
        begin
            mem_wr_en   = s1_go && do_replace;
            mem_wr_addr = s1_idx_reg;
            tdg_wr_data = tdg_new;
            mse_wr_data = mse_new;
        end
    end

    // ------------------------------------------------------------------
    // Compute stage: pick up the entry, decide, build the new words
    // ------------------------------------------------------------------
    tdg_word_t        tdg_cur;
    mse_word_t        mse_cur;
    logic             use_fwd;
    logic             same_tag;
    logic             deeper;
    logic [DEPTH_W:0] depth_plus;

    // The memory read missed a write made at the same edge: take it from
    // the forward slot instead.
    assign use_fwd = fwd_valid_reg && (fwd_idx_reg == s1_idx_reg);
    assign tdg_cur = use_fwd ? fwd_tdg_reg : tdg_rd_data;
    assign mse_cur = use_fwd ? fwd_mse_reg : mse_rd_data;

    assign same_tag   = (tdg_cur.tag == s1_tag_reg);
    assign depth_plus = {1'b0, s1_depth_reg} + DEPTH_MARGIN;
    assign deeper     = depth_plus > {1'b0, tdg_cur.depth};

    always_comb
    begin
        do_replace = (s1_cmd_reg == CMD_STORE) &&
                     (!same_tag || deeper || (s1_bound_reg == BND_EXACT));

        tdg_new.tag       = s1_tag_reg;
        tdg_new.depth     = s1_depth_reg;
        tdg_new.gen_bound = search_gen_reg | {{(GEN_W - BOUND_W){1'b0}}, s1_bound_reg};

        // Keep the old move when the store brings none for the same position.
        mse_new.move  = ((s1_move_reg != '0) || !same_tag) ? s1_move_reg : mse_cur.move;
        mse_new.score = s1_score_reg;
        mse_new.eval  = s1_eval_reg;

        res_next.hit      = (s1_cmd_reg == CMD_PROBE) && same_tag && (tdg_cur.depth != '0);
        res_next.replaced = do_replace;
        res_next.tdg      = tdg_cur;
        res_next.mse      = mse_cur;
    end

    // ------------------------------------------------------------------
    // Next-state logic for control
    // ------------------------------------------------------------------
    always_comb
    begin
        clr_addr_next   = clr_addr_reg;
        clr_active_next = clr_active_reg;
        if (clr_active_reg)
        begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == '1)
            begin
                clr_active_next = 1'b0;
            end
        end

        search_gen_next = cfg_wr_en ? cfg_wr_data : search_gen_reg;
        s1_valid_next   = in_accept || (s1_valid_reg && !s1_go);
        out_valid_next  = s1_go || (out_valid_reg && out_stall);
        fwd_valid_next  = s1_go ? do_replace : fwd_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            search_gen_reg <= '0;
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            fwd_valid_reg  <= 1'b0;
        end
        else
        begin
            clr_active_reg <= clr_active_next;
            clr_addr_reg   <= clr_addr_next;
            search_gen_reg <= search_gen_next;
            s1_valid_reg   <= s1_valid_next;
            out_valid_reg  <= out_valid_next;
            fwd_valid_reg  <= fwd_valid_next;
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_cmd_reg   <= cmd;
            s1_idx_reg   <= position_key[INDEX_BITS-1:0];
            s1_tag_reg   <= position_key[KEY_W-1:KEY_W-TAG_W];
            s1_score_reg <= score_in;
            s1_eval_reg  <= static_eval_in;
            s1_bound_reg <= bound_kind;
            s1_depth_reg <= search_depth;
            s1_move_reg  <= best_move_in;
        end
        // Track the latest write so the item right behind sees it.
        if (s1_go)
        begin
            fwd_idx_reg <= s1_idx_reg;
            fwd_tdg_reg <= tdg_new;
            fwd_mse_reg <= mse_new;
            res_reg     <= res_next;
        end
    end

    // ------------------------------------------------------------------
    // Outputs
    // ------------------------------------------------------------------
    assign out_valid       = out_valid_reg;
    assign hit             = res_reg.hit;
    assign replaced        = res_reg.replaced;
    assign entry_tag       = res_reg.tdg.tag;
    assign entry_depth     = res_reg.tdg.depth;
    assign entry_gen_bound = res_reg.tdg.gen_bound;
    assign entry_move      = res_reg.mse.move;
    assign entry_score     = res_reg.mse.score;
    assign entry_eval      = res_reg.mse.eval;

endmodule

`default_nettype wire

### tb/sv/testbench.sv
// Self-checking testbench for the direct-mapped search table: probes, stores and back-pressure.
`timescale 1ns / 1ps

module testbench;
    import dmst_pkg::*;

    // Bound on the whole run, which covers the reset sweep of every entry;
    // the slowest legal traffic stays under a third of this.
    localparam int CLK_PERIOD_NS = 20;
    localparam int RUN_LIMIT_NS  = 1_000_000 * CLK_PERIOD_NS;
    localparam int DRAIN_CYCLES  = 8;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_WORDS   = 218;

    // One probe or store as offered on the input channel.
    typedef struct {
        logic                      cmd;
        logic [KEY_W-1:0]          key;
        logic signed [VALUE_W-1:0] score;
        logic signed [VALUE_W-1:0] eval;
        logic [BOUND_W-1:0]        bound;
        logic [DEPTH_W-1:0]        depth;
        logic [MOVE_W-1:0]         move;
    } lookup_req_t;

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_wr_en;
    logic [GEN_W-1:0]          cfg_wr_data;
    logic                      in_valid;
    logic                      in_stall;
    logic                      cmd;
    logic [KEY_W-1:0]          position_key;
    logic signed [VALUE_W-1:0] score_in;
    logic signed [VALUE_W-1:0] static_eval_in;
    logic [BOUND_W-1:0]        bound_kind;
    logic [DEPTH_W-1:0]        search_depth;
    logic [MOVE_W-1:0]         best_move_in;
    logic                      out_valid;
    logic                      out_stall;
    logic                      hit;
    logic                      replaced;
    logic [TAG_W-1:0]          entry_tag;
    logic [MOVE_W-1:0]         entry_move;
    logic signed [VALUE_W-1:0] entry_score;
    logic signed [VALUE_W-1:0] entry_eval;
    logic [DEPTH_W-1:0]        entry_depth;
    logic [GEN_W-1:0]          entry_gen_bound;

    // Shadow copy of both entry memories and of the generation register.
    tdg_word_t        shadow_tdg [TABLE_DEPTH];
    mse_word_t        shadow_mse [TABLE_DEPTH];
    logic [GEN_W-1:0] shadow_generation;

    // Results still owed by the block, oldest first.
    result_t pending_results [$];
    int      mismatch_count;

    // Traffic shaping knobs, changed by the test tasks between phases.
    bit sender_gaps;
    bit sink_quiet;
    int holdoff_cycles;

    // Key pools for the random phases: a handful of slots and tags so that
    // stores collide and probes find what earlier stores left behind.
    logic [INDEX_BITS-1:0] slot_pool [8];
    logic [TAG_W-1:0]      tag_pool [4];

    direct_mapped_search_table uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .cmd             (cmd),
        .position_key    (position_key),
        .score_in        (score_in),
        .static_eval_in  (static_eval_in),
        .bound_kind      (bound_kind),
        .search_depth    (search_depth),
        .best_move_in    (best_move_in),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .hit             (hit),
        .replaced        (replaced),
        .entry_tag       (entry_tag),
        .entry_move      (entry_move),
        .entry_score     (entry_score),
        .entry_eval      (entry_eval),
        .entry_depth     (entry_depth),
        .entry_gen_bound (entry_gen_bound)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD_NS / 2) clk = ~clk;
    end

    // Hard stop in case a handshake never completes.
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("Regression FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Look up the addressed entry, report it as it stood, and apply the
    // replacement rule for a store. The depth sum is formed one bit wider
    // so that depths of 252 and up never wrap below the stored depth.
    function automatic result_t table_access(input lookup_req_t r);
        logic [INDEX_BITS-1:0] slot;
        logic [TAG_W-1:0]      key_tag;
        tdg_word_t             old_tdg;
        mse_word_t             old_mse;
        logic                  same_tag;
        logic [DEPTH_W:0]      reach;
        result_t               res;
        slot     = r.key[INDEX_BITS-1:0];
        key_tag  = r.key[KEY_W-1:KEY_W-TAG_W];
        old_tdg  = shadow_tdg[slot];
        old_mse  = shadow_mse[slot];
        same_tag = (old_tdg.tag == key_tag);
        reach    = {1'b0, r.depth} + DEPTH_MARGIN;
        res.hit      = 1'b0;
        res.replaced = 1'b0;
        res.tdg      = old_tdg;
        res.mse      = old_mse;
        if (r.cmd == CMD_PROBE)
        begin
            res.hit = same_tag && (old_tdg.depth != '0);
        end
        else if (!same_tag || reach > {1'b0, old_tdg.depth} || r.bound == BND_EXACT)
        begin
            shadow_tdg[slot].tag       = key_tag;
            shadow_tdg[slot].depth     = r.depth;
            shadow_tdg[slot].gen_bound = shadow_generation | GEN_W'(r.bound);
            // Keep the old move when refreshing the same position without one.
            shadow_mse[slot].move  = (r.move != '0 || !same_tag) ? r.move : old_mse.move;
            shadow_mse[slot].score = r.score;
            shadow_mse[slot].eval  = r.eval;
            res.replaced = 1'b1;
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic compare_field(input string field, input logic [63:0] want,
                                 input logic [63:0] got);
        if (got !== want)
        begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            mismatch_count++;
        end
    endtask

    // Compare every accepted result word with the oldest prediction.
    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t ns: result word with no prediction pending", $time);
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                compare_field("hit",             want.hit,           hit);
                compare_field("replaced",        want.replaced,      replaced);
                compare_field("entry_tag",       want.tdg.tag,       entry_tag);
                compare_field("entry_move",      want.mse.move,      entry_move);
                compare_field("entry_score",     want.mse.score,     $unsigned(entry_score));
                compare_field("entry_eval",      want.mse.eval,      $unsigned(entry_eval));
                compare_field("entry_depth",     want.tdg.depth,     entry_depth);
                compare_field("entry_gen_bound", want.tdg.gen_bound, entry_gen_bound);
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: stall pattern, one assignment per chosen run
    // ------------------------------------------------------------------

    // Pick a level and a run length, hold it, repeat. A pending hold-off
    // takes priority and is counted down here, not by the sender.
    initial
    begin : sink_driver
        int run;
        int pick;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (holdoff_cycles > 0)
            begin
                run = holdoff_cycles;
                holdoff_cycles = 0;
                out_stall <= 1'b1;
            end
            else if (sink_quiet)
            begin
                run = 16;
                out_stall <= 1'b0;
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 60)
                begin
                    run = $urandom_range(1, 6);
                    out_stall <= 1'b0;
                end
                else
                begin
                    if (pick < 92)
                        run = $urandom_range(1, 3);
                    else if (pick < 98)
                        run = $urandom_range(5, 15);
                    else
                        run = $urandom_range(30, 80);
                    out_stall <= 1'b1;
                end
            end
            repeat (run - 1) @(posedge clk);
        end
    end

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------

    function automatic int pick_sender_gap();
        int pick;
        if (!sender_gaps)
            return 0;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            return 0;
        if (pick < 90)
            return $urandom_range(1, 3);
        if (pick < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Offer one word, hold it until accepted, predict, then maybe idle.
    // Valid stays high on a zero gap so back-to-back words never drop it.
    task automatic send_word(input lookup_req_t r);
        int gap;
        cmd            <= r.cmd;
        position_key   <= r.key;
        score_in       <= r.score;
        static_eval_in <= r.eval;
        bound_kind     <= r.bound;
        search_depth   <= r.depth;
        best_move_in   <= r.move;
        in_valid       <= 1'b1;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        pending_results.push_back(table_access(r));
        gap = pick_sender_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Drop valid right away, then wait for every owed result.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Only call with the block idle. The task waits on the clock again after
    // lowering the enable so back-to-back writes never assign it twice in one step.
    task automatic write_generation(input logic [GEN_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        shadow_generation = value;
        @(posedge clk);
    endtask

    function automatic lookup_req_t make_word(
        input logic cmd_v, input logic [KEY_W-1:0] key_v,
        input logic [VALUE_W-1:0] score_v, input logic [VALUE_W-1:0] eval_v,
        input logic [BOUND_W-1:0] bound_v, input logic [DEPTH_W-1:0] depth_v,
        input logic [MOVE_W-1:0] move_v);
        lookup_req_t r;
        r.cmd   = cmd_v;
        r.key   = key_v;
        r.score = score_v;
        r.eval  = eval_v;
        r.bound = bound_v;
        r.depth = depth_v;
        r.move  = move_v;
        return r;
    endfunction

    function automatic logic [VALUE_W-1:0] random_value();
        logic [VALUE_W-1:0] corner [4];
        corner = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF};
        if ($urandom_range(0, 9) == 0)
            return corner[2'($urandom_range(0, 3))];
        return VALUE_W'($urandom);
    endfunction

    // Mostly pooled keys so entries get reused; some fully random keys
    // so every key bit toggles. Middle bits 31..16 are never indexed.
    function automatic lookup_req_t random_word();
        lookup_req_t r;
        int          pick;
        r.cmd = $urandom_range(0, 1) ? CMD_STORE : CMD_PROBE;
        if ($urandom_range(0, 99) < 85)
            r.key = {tag_pool[2'($urandom_range(0, 3))], 16'($urandom),
                     slot_pool[3'($urandom_range(0, 7))]};
        else
            r.key = {32'($urandom), 32'($urandom)};
        r.score = random_value();
        r.eval  = random_value();
        r.bound = BOUND_W'($urandom_range(0, 3));
        pick = $urandom_range(0, 99);
        if (pick < 60)
            r.depth = DEPTH_W'($urandom_range(0, 12));
        else if (pick < 85)
            r.depth = DEPTH_W'($urandom);
        else
            r.depth = DEPTH_W'($urandom_range(248, 255));
        r.move = ($urandom_range(0, 3) == 0) ? '0 : MOVE_W'($urandom);
        return r;
    endfunction

    // Refill the pools; keep the lowest and highest slot and the all-zero
    // and all-one tags in every set.
    task automatic refresh_key_pools();
        slot_pool[0] = '0;
        slot_pool[1] = '1;
        for (int i = 2; i < 8; i++)
            slot_pool[3'(i)] = INDEX_BITS'($urandom);
        tag_pool[0] = '0;
        tag_pool[1] = '1;
        tag_pool[2] = TAG_W'($urandom);
        tag_pool[3] = TAG_W'($urandom);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Empty entries, all-zero and all-one keys, extreme values.
    task automatic test_empty_and_extremes();
        send_word(make_word(CMD_PROBE, 64'h0, 16'h0, 16'h0, BND_NONE, 8'd0, 16'h0));
        send_word(make_word(CMD_PROBE, '1, 16'h0, 16'h0, BND_NONE, 8'd0, 16'h0));
        send_word(make_word(CMD_STORE, '1, 16'h7FFF, 16'h8000, BND_UPPER, 8'd255, 16'hFFFF));
        send_word(make_word(CMD_PROBE, '1, 16'h0, 16'h0, BND_NONE, 8'd0, 16'h0));
        // Same tag as a cleared entry, no move given: stored move stays zero.
        send_word(make_word(CMD_STORE, 64'h0, 16'h8000, 16'h7FFF, BND_NONE, 8'd0, 16'h0));
        // Tag matches but depth is zero: no hit.
        send_word(make_word(CMD_PROBE, 64'h0, 16'h0, 16'h0, BND_NONE, 8'd0, 16'h0));
        send_word(make_word(CMD_STORE, 64'h0000_0000_AAAA_0000, 16'hFFFF, 16'h0001,
                            BND_LOWER, 8'd1, 16'h1234));
        send_word(make_word(CMD_PROBE, 64'h0000_0000_5555_0000, 16'h0, 16'h0,
                            BND_NONE, 8'd0, 16'h0));
        drain_results();
    endtask

    // Depth margin edges, exact bound override, move retention, tag change.
    task automatic test_replacement_rules();
        localparam logic [KEY_W-1:0] KEY_A = 64'h89AB_CDEF_0000_1234;
        localparam logic [KEY_W-1:0] KEY_B = 64'h0000_0001_FFFF_1234;
        send_word(make_word(CMD_STORE, KEY_A, 16'd100, 16'd50, BND_LOWER, 8'd10, 16'h0A0A));
        // 6 + 4 does not exceed 10: keep the entry.
        send_word(make_word(CMD_STORE, KEY_A, 16'd1, 16'd2, BND_UPPER, 8'd6, 16'h0B0B));
        // 7 + 4 exceeds 10: overwrite, but keep the old move.
        send_word(make_word(CMD_STORE, KEY_A, 16'd3, 16'd4, BND_NONE, 8'd7, 16'h0));
        // Exact bound overwrites a deeper entry.
        send_word(make_word(CMD_STORE, KEY_A, 16'd5, 16'd6, BND_EXACT, 8'd2, 16'h0));
        send_word(make_word(CMD_STORE, KEY_A, 16'd7, 16'd8, BND_LOWER, 8'd255, 16'h0C0C));
        // Depth 252 plus the margin must not wrap below 255.
        send_word(make_word(CMD_STORE, KEY_A, 16'h8000, 16'h7FFF, BND_UPPER, 8'd252, 16'h0));
        send_word(make_word(CMD_STORE, KEY_A, 16'd9, 16'd9, BND_LOWER, 8'd247, 16'h0D0D));
        // New tag with no move: the old move is not carried over.
        send_word(make_word(CMD_STORE, KEY_B, 16'd11, 16'd12, BND_NONE, 8'd0, 16'h0));
        send_word(make_word(CMD_PROBE, KEY_B, 16'h0, 16'h0, BND_NONE, 8'd0, 16'h0));
        send_word(make_word(CMD_PROBE, KEY_A, 16'h0, 16'h0, BND_NONE, 8'd0, 16'h0));
        drain_results();
    endtask

    // Generation byte ORed with the bound, with the register all ones and with only its top bit set.
    task automatic test_generation_register();
        localparam logic [KEY_W-1:0] KEY_G = 64'h0000_0001_0000_00F0;
        write_generation(8'hFF);
        send_word(make_word(CMD_STORE, KEY_G, 16'd20, 16'd21, BND_NONE, 8'd3, 16'h0101));
        send_word(make_word(CMD_PROBE, KEY_G, 16'h0, 16'h0, BND_NONE, 8'd0, 16'h0));
        drain_results();
        write_generation(8'h80);
        send_word(make_word(CMD_STORE, KEY_G, 16'd22, 16'd23, BND_EXACT, 8'd0, 16'h0));
        send_word(make_word(CMD_PROBE, KEY_G, 16'h0, 16'h0, BND_NONE, 8'd0, 16'h0));
        drain_results();
    endtask

    // Hold the output off for a long stretch while the sender streams
    // gapless, so the pipeline fills and raises in_stall.
    task automatic test_output_holdoff();
        refresh_key_pools();
        write_generation(8'($urandom));
        sender_gaps    = 1'b0;
        sink_quiet     = 1'b1;
        holdoff_cycles = 60;
        repeat (40) send_word(random_word());
        drain_results();
        sink_quiet = 1'b0;
    endtask

    // Random traffic in phases, each with its own generation and key pools;
    // the first phase runs with no idling on either side.
    task automatic test_random_traffic();
        logic [GEN_W-1:0] phase_gen [RANDOM_PHASES];
        phase_gen = '{8'h00, 8'hFF, 8'($urandom), 8'h04, 8'($urandom), 8'hFC};
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            refresh_key_pools();
            write_generation(phase_gen[3'(p)]);
            sender_gaps = (p != 0) && (p != 3);
            sink_quiet  = (p == 0) || (p == 4);
            repeat (PHASE_WORDS) send_word(random_word());
            drain_results();
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        rst_n          <= 1'b0;
        cfg_wr_en      <= 1'b0;
        cfg_wr_data    <= '0;
        in_valid       <= 1'b0;
        cmd            <= CMD_PROBE;
        position_key   <= '0;
        score_in       <= '0;
        static_eval_in <= '0;
        bound_kind     <= BND_NONE;
        search_depth   <= '0;
        best_move_in   <= '0;
        mismatch_count    = 0;
        holdoff_cycles    = 0;
        sender_gaps       = 1'b1;
        sink_quiet        = 1'b0;
        shadow_generation = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            shadow_tdg[INDEX_BITS'(i)] = '0;
            shadow_mse[INDEX_BITS'(i)] = '0;
        end

        // Release reset; the block then clears its memories with in_stall
        // high, which the first word simply waits out.
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_generation(8'h00);

        test_empty_and_extremes();
        test_replacement_rules();
        test_generation_register();
        test_output_holdoff();
        test_random_traffic();

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
